/* hw/rtl/pra_pkg.sv */
// Package for the paired resource arbiter: field widths, status and kind codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package pra_pkg;

    localparam int ID_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int MAX_RESULTS = 5;
    localparam int GRANT_W     = $clog2(MAX_RESULTS + 1);

    localparam logic [STATUS_W-1:0] ST_GRANT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WAIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

    localparam logic KIND_ACQ = 1'b0;
    localparam logic KIND_REL = 1'b1;

    typedef struct packed {
        logic load;
        logic acq;
        logic rel;
        logic take;
        logic skip;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic scan_more;
        logic elig;
        logic pend_valid;
        logic out_free;
    } t_stat;

endpackage

/* hw/rtl/pra_dp.sv */
// Datapath of the paired resource arbiter: resource flags, wait list,
// scan position, pending grant and output register. Uses pra_pkg.
module pra_dp #(
    parameter int NUM_CLIENTS = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pra_pkg::ID_W-1:0]      i_requester,
    input  logic [pra_pkg::ID_W-1:0]      i_first_resource,
    input  logic [pra_pkg::ID_W-1:0]      i_second_resource,
    input  pra_pkg::t_cmd                 i_cmd,
    output pra_pkg::t_stat                o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [pra_pkg::STATUS_W-1:0]  o_out_status,
    output logic [pra_pkg::ID_W-1:0]      o_out_client,
    output logic                          o_out_last
);

    localparam int RW = ($clog2(NUM_CLIENTS + 1) > pra_pkg::ID_W) ?
                        $clog2(NUM_CLIENTS + 1) : pra_pkg::ID_W;
    localparam int FW = 1 << RW;
    localparam int IW = $clog2(NUM_CLIENTS);
    localparam int CW = $clog2(NUM_CLIENTS + 1);
    localparam logic [FW-1:0] FREE_INIT = FW'((FW'(1) << (NUM_CLIENTS + 1)) - FW'(2));
    localparam logic [RW-1:0] TOP_RES   = RW'(NUM_CLIENTS);

    logic [pra_pkg::ID_W-1:0]     r_who, n_who;
    logic [pra_pkg::ID_W-1:0]     r_ra, n_ra;
    logic [pra_pkg::ID_W-1:0]     r_rb, n_rb;
    logic [FW-1:0]                r_free, n_free;
    logic [pra_pkg::ID_W-1:0]     r_list [NUM_CLIENTS];
    logic [pra_pkg::ID_W-1:0]     n_list [NUM_CLIENTS];
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_pos, n_pos;
    logic [pra_pkg::GRANT_W-1:0]  r_ngrant, n_ngrant;
    logic                         r_pend_valid, n_pend_valid;
    logic [pra_pkg::ID_W-1:0]     r_pend_client, n_pend_client;
    logic                         r_out_valid, n_out_valid;
    logic [pra_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [pra_pkg::ID_W-1:0]     r_out_client, n_out_client;
    logic                         r_out_last, n_out_last;

    logic [RW-1:0]                ra_e, rb_e, who_e, id_e, other_e;
    logic [pra_pkg::ID_W-1:0]     cur_id;
    logic [CW-1:0]                cnt_m1;
    logic                         who_ok, ra_ok, rb_ok, full, scan_more, out_free;

    assign ra_e      = RW'(r_ra);
    assign rb_e      = RW'(r_rb);
    assign who_e     = RW'(r_who);
    assign ra_ok     = (r_ra != '0) && (ra_e <= TOP_RES);
    assign rb_ok     = (r_rb != '0) && (rb_e <= TOP_RES);
    assign who_ok    = (r_who != '0) && (who_e <= TOP_RES);
    assign full      = (r_count >= CW'(NUM_CLIENTS));
    assign cur_id    = r_list[r_pos[IW-1:0]];
    assign id_e      = RW'(cur_id);
    assign other_e   = (id_e > RW'(1)) ? (id_e - RW'(1)) : TOP_RES;
    assign cnt_m1    = r_count - CW'(1);
    assign scan_more = (r_pos < r_count) &&
                       (r_ngrant < pra_pkg::GRANT_W'(pra_pkg::MAX_RESULTS));
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_stat.scan_more  = scan_more;
    assign o_stat.elig       = scan_more && r_free[id_e] && r_free[other_e];
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = out_free;

    always_comb begin
        n_who         = r_who;
        n_ra          = r_ra;
        n_rb          = r_rb;
        n_free        = r_free;
        n_list        = r_list;
        n_count       = r_count;
        n_pos         = r_pos;
        n_ngrant      = r_ngrant;
        n_pend_valid  = r_pend_valid;
        n_pend_client = r_pend_client;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_status  = r_out_status;
        n_out_client  = r_out_client;
        n_out_last    = r_out_last;

        if (i_cmd.load) begin
            n_who  = i_requester;
            n_ra   = i_first_resource;
            n_rb   = i_second_resource;
        end

        if (i_cmd.acq) begin
            n_out_valid  = 1'b1;
            n_out_client = r_who;
            n_out_last   = 1'b1;
            if (r_free[ra_e] && r_free[rb_e]) begin
                n_free[ra_e] = 1'b0;
                n_free[rb_e] = 1'b0;
                n_out_status = pra_pkg::ST_GRANT;
            end else if (!who_ok || full) begin
                n_out_status = pra_pkg::ST_DROP;
            end else begin
                n_list[r_count[IW-1:0]] = r_who;
                n_count                 = r_count + CW'(1);
                n_out_status            = pra_pkg::ST_WAIT;
            end
        end

        if (i_cmd.rel) begin
            if (ra_ok) begin
                n_free[ra_e] = 1'b1;
            end
            if (rb_ok) begin
                n_free[rb_e] = 1'b1;
            end
            n_pos        = '0;
            n_ngrant     = '0;
            n_pend_valid = 1'b0;
        end

        if (i_cmd.take) begin
            n_free[id_e]    = 1'b0;
            n_free[other_e] = 1'b0;
            for (int i = 0; i < NUM_CLIENTS - 1; i++) begin
                if ((CW'(i) >= r_pos) && (CW'(i + 1) < r_count)) begin
                    n_list[i] = r_list[i + 1];
                end
            end
            n_list[cnt_m1[IW-1:0]] = '0;
            n_count  = cnt_m1;
            n_ngrant = r_ngrant + pra_pkg::GRANT_W'(1);
            if (r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out_status = pra_pkg::ST_GRANT;
                n_out_client = r_pend_client;
                n_out_last   = 1'b0;
            end
            n_pend_valid  = 1'b1;
            n_pend_client = cur_id;
        end

        if (i_cmd.skip) begin
            n_pos = r_pos + CW'(1);
        end

        if (i_cmd.flush) begin
            n_out_valid  = 1'b1;
            n_out_status = pra_pkg::ST_GRANT;
            n_out_client = r_pend_client;
            n_out_last   = 1'b1;
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free       <= FREE_INIT;
            r_count      <= '0;
            r_pos        <= '0;
            r_ngrant     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_free       <= n_free;
            r_count      <= n_count;
            r_pos        <= n_pos;
            r_ngrant     <= n_ngrant;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_who         <= n_who;
        r_ra          <= n_ra;
        r_rb          <= n_rb;
        r_list        <= n_list;
        r_pend_client <= n_pend_client;
        r_out_status  <= n_out_status;
        r_out_client  <= n_out_client;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_client = r_out_client;
    assign o_out_last   = r_out_last;

endmodule

/* hw/rtl/pra_ctrl.sv */
// Controller of the paired resource arbiter: sequences acquire, release
// and wait-list scan steps. Uses pra_pkg.
module pra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_kind,
    output logic           o_in_ready,
    input  pra_pkg::t_stat i_stat,
    output pra_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ACQ  = 2'd1;
    localparam logic [1:0] S_REL  = 2'd2;
    localparam logic [1:0] S_SCAN = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_in_kind == pra_pkg::KIND_REL) ? S_REL : S_ACQ;
                end
            end
            S_ACQ: begin
                if (i_stat.out_free) begin
                    o_cmd.acq = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_REL: begin
                o_cmd.rel = 1'b1;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_more) begin
                    if (!i_stat.elig) begin
                        o_cmd.skip = 1'b1;
                    end else if (!i_stat.pend_valid || i_stat.out_free) begin
                        o_cmd.take = 1'b1;
                    end
                end else if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/paired_resource_arbiter.sv */
// Top level of the paired resource arbiter: stream ports, controller and datapath.
// Depends on pra_pkg, pra_ctrl and pra_dp.
//
//  channel   direction  tdata                                 tuser     tlast
//  s_axis    in         [2:0] requester, [5:3] first_resource, [0] kind  -
//                       [8:6] second_resource
//  m_axis    out        [2:0] client                          [1:0] status  last
//
// An acquire is loaded, then its result is written to the output register once
// that is free; no request is taken before then. A release frees its resources, then
// the scan steps one wait entry a cycle, granted or not, but a grant may stall.
// Reset is synchronous, active low: all resources free, wait list empty.
// A full output register stalls the controller on the next result.
module paired_resource_arbiter #(
    parameter int NUM_CLIENTS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // requester, first_resource, second_resource
    input  logic [0:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // client
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast
);

    pra_pkg::t_cmd  cmd;
    pra_pkg::t_stat stat;
    logic [pra_pkg::ID_W-1:0] out_client;

    pra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pra_dp #(
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_requester       (s_axis_tdata[2:0]),
        .i_first_resource  (s_axis_tdata[5:3]),
        .i_second_resource (s_axis_tdata[8:6]),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_out_status      (m_axis_tuser),
        .o_out_client      (out_client),
        .o_out_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, out_client};

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for paired_resource_arbiter: a directed table, then random
// acquire and release transactions checked against a behavioral arbiter in this file.
// Depends on pra_pkg and the paired_resource_arbiter RTL.
module testbench;
    import pra_pkg::*;

    localparam int CLIENTS       = 5;
    localparam int PLAN_LEN      = 22;
    localparam int RANDOM_ITEMS  = 88;
    localparam int IDLE_LIMIT    = 1500;
    localparam int HOLD_CYCLES   = 120;
    localparam int HOLD_AFTER    = 35;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     client;
        logic                last;
    } t_answer;

    typedef struct packed {
        logic                kind;
        logic [ID_W-1:0]     who;
        logic [ID_W-1:0]     ra;
        logic [ID_W-1:0]     rb;
        logic                typed;
        logic [STATUS_W-1:0] st;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // requester, first_resource, second_resource
    logic [0:0]  s_axis_tuser = '0;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // client
    logic [1:0]  m_axis_tuser;        // status
    logic        m_axis_tlast;

    logic [7:0]      free_mask;
    logic [ID_W-1:0] waiters[$];
    t_answer         answer_q[$];
    int              faults = 0;
    int              accepted_items = 0;
    int              idle_cycles = 0;
    bit              no_gaps = 1'b0;

    t_plan_row plan [PLAN_LEN] = '{
        '{KIND_ACQ, 3'd1, 3'd1, 3'd5, 1'b1, ST_GRANT},
        '{KIND_ACQ, 3'd2, 3'd2, 3'd1, 1'b1, ST_WAIT},
        '{KIND_ACQ, 3'd0, 3'd1, 3'd2, 1'b1, ST_DROP},
        '{KIND_ACQ, 3'd6, 3'd6, 3'd1, 1'b1, ST_DROP},
        '{KIND_ACQ, 3'd3, 3'd3, 3'd3, 1'b1, ST_GRANT},
        '{KIND_ACQ, 3'd4, 3'd0, 3'd4, 1'b1, ST_WAIT},
        '{KIND_ACQ, 3'd5, 3'd7, 3'd6, 1'b1, ST_WAIT},
        '{KIND_ACQ, 3'd7, 3'd2, 3'd4, 1'b1, ST_GRANT},
        '{KIND_ACQ, 3'd2, 3'd2, 3'd2, 1'b1, ST_WAIT},
        '{KIND_ACQ, 3'd1, 3'd1, 3'd1, 1'b1, ST_WAIT},
        '{KIND_ACQ, 3'd3, 3'd3, 3'd2, 1'b1, ST_DROP},
        '{KIND_REL, 3'd1, 3'd0, 3'd7, 1'b0, ST_GRANT},
        '{KIND_REL, 3'd1, 3'd1, 3'd5, 1'b0, ST_GRANT},
        '{KIND_REL, 3'd3, 3'd3, 3'd2, 1'b0, ST_GRANT},
        '{KIND_REL, 3'd4, 3'd4, 3'd4, 1'b0, ST_GRANT},
        '{KIND_REL, 3'd2, 3'd5, 3'd1, 1'b0, ST_GRANT},
        '{KIND_ACQ, 3'd5, 3'd5, 3'd4, 1'b0, ST_GRANT},
        '{KIND_REL, 3'd5, 3'd5, 3'd4, 1'b0, ST_GRANT},
        '{KIND_REL, 3'd0, 3'd7, 3'd6, 1'b0, ST_GRANT},
        '{KIND_ACQ, 3'd4, 3'd4, 3'd3, 1'b0, ST_GRANT},
        '{KIND_REL, 3'd4, 3'd4, 3'd3, 1'b0, ST_GRANT},
        '{KIND_REL, 3'd2, 3'd1, 3'd2, 1'b0, ST_GRANT}
    };

    paired_resource_arbiter #(
        .NUM_CLIENTS(CLIENTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic usable(input logic [ID_W-1:0] r);
        return (r >= 1) && (r <= CLIENTS) && free_mask[r];
    endfunction

    task automatic mark(input logic [ID_W-1:0] r, input logic val);
        if (r >= 1 && r <= CLIENTS) free_mask[r] = val;
    endtask

    task automatic resolve_request(input logic kind, input logic [ID_W-1:0] who,
                                   input logic [ID_W-1:0] ra, input logic [ID_W-1:0] rb);
        t_answer         fresh[$];
        t_answer         tail;
        int              pos;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] other;
        pos = 0;
        if (kind == KIND_ACQ) begin
            if (usable(ra) && usable(rb)) begin
                mark(ra, 1'b0);
                mark(rb, 1'b0);
                fresh.push_back('{ST_GRANT, who, 1'b0});
            end else if (who == 0 || who > CLIENTS || waiters.size() >= CLIENTS) begin
                fresh.push_back('{ST_DROP, who, 1'b0});
            end else begin
                waiters.push_back(who);
                fresh.push_back('{ST_WAIT, who, 1'b0});
            end
        end else begin
            mark(ra, 1'b1);
            mark(rb, 1'b1);
            while (pos < waiters.size() && fresh.size() < MAX_RESULTS) begin
                id = waiters[pos];
                other = (id > 1) ? id - 3'd1 : ID_W'(CLIENTS);
                if (usable(id) && usable(other)) begin
                    mark(id, 1'b0);
                    mark(other, 1'b0);
                    waiters.delete(pos);
                    fresh.push_back('{ST_GRANT, id, 1'b0});
                end else begin
                    pos++;
                end
            end
        end
        if (fresh.size() > 0) begin
            tail = fresh.pop_back();
            tail.last = 1'b1;
            fresh.push_back(tail);
        end
        foreach (fresh[i]) answer_q.push_back(fresh[i]);
    endtask

    task automatic offer(input t_plan_row row);
        while (!no_gaps && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, row.rb, row.ra, row.who};
        s_axis_tuser  <= row.kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        accepted_items++;
        resolve_request(row.kind, row.who, row.ra, row.rb);
        if (row.typed) begin
            void'(answer_q.pop_back());
            answer_q.push_back('{row.st, row.who, 1'b1});
        end
        @(negedge i_clk);
    endtask

    task automatic flag(input string msg);
        faults++;
        if (faults <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
    endtask

    initial begin
        t_plan_row row;
        int        c;
        int        below;
        int        p;
        free_mask = '0;
        for (int r = 1; r <= CLIENTS; r++) free_mask[r] = 1'b1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (plan[i]) offer(plan[i]);
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            no_gaps = (k >= 40 && k < 70);
            p = $urandom_range(99);
            c = $urandom_range(CLIENTS, 1);
            below = (c > 1) ? c - 1 : CLIENTS;
            row = '0;
            if (p < 75) begin
                row.kind = (p < 40) ? KIND_ACQ : KIND_REL;
                row.who  = ID_W'(c);
                if ($urandom_range(1)) begin
                    row.ra = ID_W'(c);
                    row.rb = ID_W'(below);
                end else begin
                    row.ra = ID_W'(below);
                    row.rb = ID_W'(c);
                end
            end else begin
                row.kind = 1'($urandom_range(1));
                row.who  = ID_W'($urandom_range(7));
                row.ra   = ID_W'($urandom_range(7));
                row.rb   = ID_W'($urandom_range(7));
            end
            offer(row);
        end
        no_gaps = 1'b0;
        s_axis_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (faults == 0) begin
            $display("paired_resource_arbiter regression: pass");
        end else begin
            $display("paired_resource_arbiter regression: fail");
        end
        $finish;
    end

    // hold off once for a long stretch so the block backs up into its input
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && accepted_items >= HOLD_AFTER) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_gaps || ($urandom_range(99) >= 33);
            end
        end
    end

    always @(posedge i_clk) begin : check_answers
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answer_q.size() == 0) begin
                flag($sformatf("unexpected transaction: status %0d client %0d last %0d",
                               m_axis_tuser, m_axis_tdata[2:0], m_axis_tlast));
            end else begin
                want = answer_q.pop_front();
                if (m_axis_tuser !== want.status || m_axis_tdata[2:0] !== want.client
                        || m_axis_tlast !== want.last) begin
                    flag($sformatf("mismatch: status %0d/%0d client %0d/%0d last %0d/%0d",
                                   want.status, m_axis_tuser, want.client,
                                   m_axis_tdata[2:0], want.last, m_axis_tlast));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("paired_resource_arbiter regression: fail");
                $finish;
            end
        end
    end

endmodule
